### rtl/crcb_pkg.sv
`timescale 1ns / 1ps
// Package for the chirp rate correlator bank: widths, register indexes,
// the per-rate memory entry layout and the quarter-wave sine table.
// No dependencies; the other files of the block import it, all but crcb_ram.
package crcb_pkg;

   // Block dimensions.
   localparam int NUM_RATES        = 64;
   localparam int MAX_SAMPLES_LOG2 = 20;
   localparam int SINE_INDEX_BITS  = 10;

   // Field widths.
   localparam int RATE_W      = 6;
   localparam int RATE_CNT_W  = RATE_W + 1;
   localparam int PHASE_W     = 48;
   localparam int CU_W        = 32;
   localparam int TS_W        = 32;
   localparam int SUM_W       = 52;
   localparam int PROD_W      = 32;
   localparam int SAMPLE_W    = 16;
   localparam int SINE_W      = 16;
   localparam int SINE_MAG_W  = 15;
   localparam int AREA_W      = 52;
   localparam int MAG_W       = SUM_W + 2;
   localparam int CUR_W       = CU_W + RATE_W;
   localparam int COUNT_W     = MAX_SAMPLES_LOG2 + 1;
   localparam int RATES_W     = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 48;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(1) << MAX_SAMPLES_LOG2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_PHASE_STEP = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_CHIRP_UNIT      = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_TIME_STEP       = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_RATES_IN_USE    = CSR_INDEX_W'(3);

   // Configuration reset values.
   localparam logic [PHASE_W-1:0] BASE_PHASE_STEP_RESET = 48'd844424930132;
   localparam logic [CU_W-1:0]    CHIRP_UNIT_RESET      = 32'd28147;
   localparam logic [TS_W-1:0]    TIME_STEP_RESET       = 32'd429497;
   localparam logic [RATES_W-1:0] RATES_IN_USE_RESET    = 7'd64;

   // One memory word per chirp rate.
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [PHASE_W-1:0] step;
      logic [SUM_W-1:0]   sum;
      logic [PROD_W-1:0]  first_prod;
      logic [PROD_W-1:0]  last_prod;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Control from the sequencer to the template update pipeline.
   typedef struct packed {
      logic                       issue;
      logic [RATE_W-1:0]          rate;
      logic                       block_start;
      logic signed [SAMPLE_W-1:0] sample;
   } tmpl_ctl_type;

   // Quarter-wave sine table, Q15, built at elaboration.
   localparam int QUARTER_BITS = SINE_INDEX_BITS - 2;
   localparam int QUARTER      = 1 << QUARTER_BITS;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef logic [QUARTER-1:0][SINE_MAG_W-1:0] qtab_type;

   // First-quadrant sine by an 8-term Taylor series in Q30. Each term is the
   // previous one times theta^2 over (2k)(2k+1), with alternating signs.
   function automatic logic [SINE_MAG_W-1:0] quarter_sine(input longint unsigned m);
      longint unsigned theta;
      longint unsigned t2;
      longint unsigned term;
      longint          acc;
      theta = (m * HALF_PI_Q30) >> (SINE_INDEX_BITS - 2);
      t2    = (theta * theta) >> 30;
      term  = theta;
      acc   = longint'(theta);
      term  = ((term * t2) >> 30) / 64'd6;
      acc   = acc - longint'(term);
      term  = ((term * t2) >> 30) / 64'd20;
      acc   = acc + longint'(term);
      term  = ((term * t2) >> 30) / 64'd42;
      acc   = acc - longint'(term);
      term  = ((term * t2) >> 30) / 64'd72;
      acc   = acc + longint'(term);
      term  = ((term * t2) >> 30) / 64'd110;
      acc   = acc - longint'(term);
      term  = ((term * t2) >> 30) / 64'd156;
      acc   = acc + longint'(term);
      term  = ((term * t2) >> 30) / 64'd210;
      acc   = acc - longint'(term);
      if (acc < 0) acc = 0;
      acc = (acc + 16384) >> 15;
      if (acc > 32767) acc = 32767;
      return SINE_MAG_W'(acc);
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type t;
      int       i;
      for (i = 0; i < QUARTER; i++) begin
         t[i] = quarter_sine(i);
      end
      return t;
   endfunction

   localparam qtab_type                SINE_QTAB = build_qtab();
   localparam logic [SINE_MAG_W-1:0]   SINE_PEAK = quarter_sine(QUARTER);

   // Full-circle sine from the quarter table by quadrant symmetry.
   function automatic logic signed [SINE_W-1:0] sine_lookup(
      input logic [SINE_INDEX_BITS-1:0] idx
   );
      logic [1:0]              quad;
      logic [QUARTER_BITS-1:0] m;
      logic [QUARTER_BITS-1:0] m_rev;
      logic [SINE_MAG_W-1:0]   mag;
      quad  = idx[SINE_INDEX_BITS-1 -: 2];
      m     = idx[QUARTER_BITS-1:0];
      m_rev = '0 - m;
      if (quad[0]) begin
         mag = (m == '0) ? SINE_PEAK : SINE_QTAB[m_rev];
      end else begin
         mag = SINE_QTAB[m];
      end
      if (quad[1]) return -$signed({1'b0, mag});
      else return $signed({1'b0, mag});
   endfunction

endpackage

### rtl/crcb_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the chirp rate correlator bank: sample requests,
// rate results and configuration writes. Depends on crcb_pkg.
interface crcb_req_if import crcb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_sample;

   modport source (output valid, sample, last_sample, input ready);
   modport sink (input valid, sample, last_sample, output ready);
endinterface

interface crcb_rsp_if import crcb_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [RATE_W-1:0]        rate_index;
   logic signed [AREA_W-1:0] area;
   logic                     count_overflow;
   logic                     last_result;

   modport source (output valid, rate_index, area, count_overflow, last_result,
                   input ready);
   modport sink (input valid, rate_index, area, count_overflow, last_result,
                 output ready);
endinterface

interface crcb_csr_if import crcb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/crcb_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module crcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/crcb_tmpl.sv
`timescale 1ns / 1ps
// Template update pipeline: read-modify-write of one rate entry per cycle
// (phase, phase step, product sum, first and last product). Depends on crcb_pkg.
module crcb_tmpl import crcb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  tmpl_ctl_type       ctl,
   input  logic [PHASE_W-1:0] base_phase_step,
   input  logic [CU_W-1:0]    chirp_unit,
   input  entry_type          rd_entry,
   output logic               wr_en,
   output logic [RATE_W-1:0]  wr_addr,
   output entry_type          wr_entry,
   output logic               busy
);

   // Stage 1: memory read in flight, chirp_unit * rate computed.
   logic               s1_valid_ff;
   logic [RATE_W-1:0]  s1_rate_ff;
   logic [CUR_W-1:0]   s1_cur_ff;

   // Stage 2: sine looked up, phase and step advanced.
   logic                     s2_valid_ff;
   logic [RATE_W-1:0]        s2_rate_ff;
   logic signed [SINE_W-1:0] s2_sine_ff;
   logic [PHASE_W-1:0]       s2_phase_ff;
   logic [PHASE_W-1:0]       s2_step_ff;
   logic [SUM_W-1:0]         s2_sum_ff;
   logic [PROD_W-1:0]        s2_first_ff;

   // Stage 3: product formed, accumulated on write-back.
   logic                     s3_valid_ff;
   logic [RATE_W-1:0]        s3_rate_ff;
   logic signed [PROD_W-1:0] s3_prod_ff;
   logic [PHASE_W-1:0]       s3_phase_ff;
   logic [PHASE_W-1:0]       s3_step_ff;
   logic [SUM_W-1:0]         s3_sum_ff;
   logic [PROD_W-1:0]        s3_first_ff;

   logic [PHASE_W-1:0]         cur_ext;
   logic [PHASE_W-1:0]         twice_ext;
   logic [SINE_INDEX_BITS-1:0] sine_idx;
   logic [PHASE_W-1:0]         phase_in;
   logic [PHASE_W-1:0]         step_in;
   logic [SUM_W-1:0]           sum_sel;
   logic signed [PROD_W-1:0]   prod_in;

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctl.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 1 payload: per-rate chirp increment.
   always_ff @(posedge clock) begin
      s1_rate_ff <= ctl.rate;
      s1_cur_ff  <= CUR_W'(chirp_unit) * CUR_W'(ctl.rate);
   end

   // Phase and step update. A block start ignores the stored entry and starts
   // from phase zero and the initial step base + unit*r.
   always_comb begin
      cur_ext   = PHASE_W'(s1_cur_ff);
      twice_ext = PHASE_W'({s1_cur_ff, 1'b0});
      if (ctl.block_start) begin
         sine_idx = '0;
         phase_in = base_phase_step + cur_ext;
         step_in  = base_phase_step + cur_ext + twice_ext;
         sum_sel  = '0;
      end else begin
         sine_idx = rd_entry.phase[PHASE_W-1 -: SINE_INDEX_BITS];
         phase_in = rd_entry.phase + rd_entry.step;
         step_in  = rd_entry.step + twice_ext;
         sum_sel  = rd_entry.sum;
      end
   end

   always_ff @(posedge clock) begin
      s2_rate_ff  <= s1_rate_ff;
      s2_sine_ff  <= sine_lookup(sine_idx);
      s2_phase_ff <= phase_in;
      s2_step_ff  <= step_in;
      s2_sum_ff   <= sum_sel;
      s2_first_ff <= rd_entry.first_prod;
   end

   // Stage 2: sample times sine.
   assign prod_in = ctl.sample * s2_sine_ff;

   always_ff @(posedge clock) begin
      s3_rate_ff  <= s2_rate_ff;
      s3_prod_ff  <= prod_in;
      s3_phase_ff <= s2_phase_ff;
      s3_step_ff  <= s2_step_ff;
      s3_sum_ff   <= s2_sum_ff;
      s3_first_ff <= s2_first_ff;
   end

   // Stage 3: accumulate and write the entry back.
   always_comb begin
      wr_entry.phase      = s3_phase_ff;
      wr_entry.step       = s3_step_ff;
      wr_entry.sum        = s3_sum_ff + {{(SUM_W - PROD_W){s3_prod_ff[PROD_W-1]}}, s3_prod_ff};
      wr_entry.first_prod = ctl.block_start ? s3_prod_ff : s3_first_ff;
      wr_entry.last_prod  = s3_prod_ff;
   end

   assign wr_en   = s3_valid_ff;
   assign wr_addr = s3_rate_ff;
   assign busy    = s1_valid_ff | s2_valid_ff | s3_valid_ff;

endmodule

### rtl/crcb_trap.sv
`timescale 1ns / 1ps
// Trapezoid area unit: time_step * (2*sum - first - last) / 2^33, rounded
// half away from zero and saturated, one at a time. Depends on crcb_pkg.
module crcb_trap import crcb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  entry_type                entry,
   input  logic [TS_W-1:0]          time_step,
   output logic                     done,
   output logic signed [AREA_W-1:0] area
);

   localparam logic [2:0] TS_IDLE = 3'd0;
   localparam logic [2:0] TS_LO   = 3'd1;
   localparam logic [2:0] TS_HI   = 3'd2;
   localparam logic [2:0] TS_ADD  = 3'd3;
   localparam logic [2:0] TS_RND  = 3'd4;

   localparam int X_W = MAG_W + 1;
   localparam logic [X_W-1:0] LIM = X_W'(1) << (AREA_W - 1);

   logic [2:0]              step_ff;
   logic [2:0]              step_in;
   logic                    done_ff;
   logic                    neg_ff;
   logic [MAG_W-1:0]        mag_ff;
   logic [TS_W-1:0]         ts_ff;
   logic [2*TS_W-1:0]       prod_ff;
   logic [TS_W-1:0]         lo_top_ff;
   logic [X_W-1:0]          x_ff;
   logic [AREA_W-1:0]       area_ff;

   logic signed [MAG_W-1:0] d_c;
   logic [MAG_W-1:0]        mag_c;
   logic [TS_W-1:0]         mul_b;
   logic [2*TS_W-1:0]       mul_p;
   logic [X_W:0]            q_wide;
   logic [X_W-1:0]          q_c;
   logic [X_W-1:0]          q_sat;
   logic [AREA_W-1:0]       area_c;

   // Twice the sum less both end products, as a sign and magnitude.
   always_comb begin
      d_c = $signed({entry.sum[SUM_W-1], entry.sum, 1'b0})
          - $signed({{(MAG_W - PROD_W){entry.first_prod[PROD_W-1]}}, entry.first_prod})
          - $signed({{(MAG_W - PROD_W){entry.last_prod[PROD_W-1]}}, entry.last_prod});
      mag_c = d_c[MAG_W-1] ? MAG_W'(-d_c) : MAG_W'(d_c);
   end

   // One 32x32 multiplier shared by the low and high halves.
   assign mul_b = (step_ff == TS_LO) ? mag_ff[TS_W-1:0] : TS_W'(mag_ff[MAG_W-1:TS_W]);
   assign mul_p = ts_ff * mul_b;

   // Rounding and saturation.
   always_comb begin
      q_wide = ({1'b0, x_ff} + (X_W + 1)'(1)) >> 1;
      q_c    = q_wide[X_W-1:0];
      if (neg_ff) begin
         q_sat  = (q_c > LIM) ? LIM : q_c;
         area_c = '0 - q_sat[AREA_W-1:0];
      end else begin
         q_sat  = (q_c > LIM - X_W'(1)) ? LIM - X_W'(1) : q_c;
         area_c = q_sat[AREA_W-1:0];
      end
   end

   always_comb begin
      step_in = step_ff;
      case (step_ff)
         TS_IDLE: if (start) step_in = TS_LO;
         TS_LO:   step_in = TS_HI;
         TS_HI:   step_in = TS_ADD;
         TS_ADD:  step_in = TS_RND;
         TS_RND:  step_in = TS_IDLE;
         default: step_in = TS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= TS_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= (step_ff == TS_RND);
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (step_ff == TS_IDLE && start) begin
         neg_ff <= d_c[MAG_W-1];
         mag_ff <= mag_c;
         ts_ff  <= time_step;
      end
      if (step_ff == TS_LO || step_ff == TS_HI) prod_ff <= mul_p;
      if (step_ff == TS_HI) lo_top_ff <= prod_ff[2*TS_W-1:TS_W];
      if (step_ff == TS_ADD) x_ff <= X_W'(prod_ff[MAG_W-1:0]) + X_W'(lo_top_ff);
      if (step_ff == TS_RND) area_ff <= area_c;
   end

   assign done = done_ff;
   assign area = area_ff;

endmodule

### rtl/chirp_rate_correlator_bank_core.sv
`timescale 1ns / 1ps
// Top level of the chirp rate correlator bank: configuration registers,
// sequencer, rate memory and result register. Depends on crcb_pkg, crcb_if,
// crcb_ram, crcb_tmpl and crcb_trap.
//
// Usage:
//    req_ch carries one signed sample per request; last_sample closes a block.
//    rsp_ch returns one result per reported rate, rates 0 to n-1 in order,
//    the final one flagged by last_result. csr_ch writes the four
//    configuration registers; it is always ready.
//    Every sample under the count limit sweeps all 64 entries of the rate
//    memory, one read-modify-write per cycle: once it is accepted, its 64
//    updates are issued, then the three-stage update pipeline drains.
//    After a last sample each result passes a memory read, the trapezoid
//    unit and a load into the result register once the old one has gone.
//    The next block's first sample is accepted as soon as the final result
//    sits in the result register.
//    Reset returns the registers to their defaults and starts a new block;
//    the memory needs no clearing pass because a block's first sample
//    overwrites every entry. A stalled receiver holds the result register
//    and pauses the result sequence; nothing is dropped.
module chirp_rate_correlator_bank_core import crcb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   crcb_req_if.sink   req_ch,
   crcb_rsp_if.source rsp_ch,
   crcb_csr_if.sink   csr_ch
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SWEEP    = 3'd1;
   localparam logic [2:0] ST_DRAIN    = 3'd2;
   localparam logic [2:0] ST_FIN_RD   = 3'd3;
   localparam logic [2:0] ST_FIN_CALC = 3'd4;
   localparam logic [2:0] ST_FIN_PUT  = 3'd5;

   // Configuration registers.
   logic [PHASE_W-1:0] base_ff;
   logic [CU_W-1:0]    cu_ff;
   logic [TS_W-1:0]    ts_ff;
   logic [RATES_W-1:0] rates_ff;

   // Sequencer state.
   logic [2:0]                 state_ff, state_in;
   logic [RATE_W-1:0]          rate_ff, rate_in;
   logic [RATE_CNT_W-1:0]      n_ff, n_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic                       ovf_ff, ovf_in;
   logic signed [SAMPLE_W-1:0] smp_ff, smp_in;
   logic                       last_ff, last_in;
   logic                       start_ff, start_in;
   logic                       fin_go_ff, fin_go_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]        rsp_rate_ff;
   logic signed [AREA_W-1:0] rsp_area_ff;
   logic                     rsp_ovf_ff;
   logic                     rsp_last_ff;

   logic                  req_accept;
   logic                  rsp_load;
   logic                  fin_last;
   logic [RATE_CNT_W-1:0] n_c;
   tmpl_ctl_type          tmpl_ctl;
   logic                  tmpl_busy;
   logic                  mem_we;
   logic [RATE_W-1:0]     mem_waddr;
   entry_type             mem_wdata;
   logic                  mem_re;
   entry_type             mem_rdata;
   logic                  trap_done;
   logic signed [AREA_W-1:0] trap_area;

   // Configuration writes.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_PHASE_STEP_RESET;
         cu_ff    <= CHIRP_UNIT_RESET;
         ts_ff    <= TIME_STEP_RESET;
         rates_ff <= RATES_IN_USE_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_BASE_PHASE_STEP: base_ff  <= csr_ch.data[PHASE_W-1:0];
            REG_CHIRP_UNIT:      cu_ff    <= csr_ch.data[CU_W-1:0];
            REG_TIME_STEP:       ts_ff    <= csr_ch.data[TS_W-1:0];
            REG_RATES_IN_USE:    rates_ff <= csr_ch.data[RATES_W-1:0];
            default: ;
         endcase
      end
   end

   // Number of reported rates, clamped to 1..NUM_RATES.
   always_comb begin
      if (rates_ff == '0) n_c = RATE_CNT_W'(1);
      else if (rates_ff > RATES_W'(NUM_RATES)) n_c = RATE_CNT_W'(NUM_RATES);
      else n_c = RATE_CNT_W'(rates_ff);
   end

   assign req_accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_load     = (state_ff == ST_FIN_PUT) && (!rsp_valid_ff || rsp_ch.ready);
   assign fin_last     = (RATE_CNT_W'(rate_ff) + RATE_CNT_W'(1)) == n_ff;

   // Sequencer: accept, sweep all rates, drain; results after a last sample.
   always_comb begin
      state_in  = state_ff;
      rate_in   = rate_ff;
      n_in      = n_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      smp_in    = smp_ff;
      last_in   = last_ff;
      start_in  = start_ff;
      fin_go_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               smp_in   = req_ch.sample;
               last_in  = req_ch.last_sample;
               start_in = (count_ff == '0);
               rate_in  = '0;
               n_in     = n_c;
               if (count_ff == MAX_COUNT) begin
                  // Sample beyond the maximum count: dropped, flag raised.
                  ovf_in = 1'b1;
                  if (req_ch.last_sample) state_in = ST_FIN_RD;
               end else begin
                  count_in = count_ff + COUNT_W'(1);
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            if (rate_ff == RATE_W'(NUM_RATES - 1)) state_in = ST_DRAIN;
            else rate_in = rate_ff + RATE_W'(1);
         end
         ST_DRAIN: begin
            if (!tmpl_busy) begin
               rate_in  = '0;
               state_in = last_ff ? ST_FIN_RD : ST_IDLE;
            end
         end
         ST_FIN_RD: begin
            fin_go_in = 1'b1;
            state_in  = ST_FIN_CALC;
         end
         ST_FIN_CALC: begin
            if (trap_done) state_in = ST_FIN_PUT;
         end
         ST_FIN_PUT: begin
            if (rsp_load) begin
               if (fin_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  rate_in  = rate_ff + RATE_W'(1);
                  state_in = ST_FIN_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rate_ff   <= '0;
         n_ff      <= RATE_CNT_W'(1);
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         last_ff   <= 1'b0;
         start_ff  <= 1'b0;
         fin_go_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rate_ff   <= rate_in;
         n_ff      <= n_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         last_ff   <= last_in;
         start_ff  <= start_in;
         fin_go_ff <= fin_go_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in;
   end

   // Rate memory and the update pipeline around it.
   assign mem_re = (state_ff == ST_SWEEP) || (state_ff == ST_FIN_RD);

   always_comb begin
      tmpl_ctl.issue       = (state_ff == ST_SWEEP);
      tmpl_ctl.rate        = rate_ff;
      tmpl_ctl.block_start = start_ff;
      tmpl_ctl.sample      = smp_ff;
   end

   crcb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_RATES)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (rate_ff),
      .rdata (mem_rdata)
   );

   crcb_tmpl u_tmpl (
      .clock           (clock),
      .reset           (reset),
      .ctl             (tmpl_ctl),
      .base_phase_step (base_ff),
      .chirp_unit      (cu_ff),
      .rd_entry        (mem_rdata),
      .wr_en           (mem_we),
      .wr_addr         (mem_waddr),
      .wr_entry        (mem_wdata),
      .busy            (tmpl_busy)
   );

   crcb_trap u_trap (
      .clock     (clock),
      .reset     (reset),
      .start     (fin_go_ff),
      .entry     (mem_rdata),
      .time_step (ts_ff),
      .done      (trap_done),
      .area      (trap_area)
   );

   // Result register; a new result loads only when the old one has gone.
   always_comb begin
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_rate_ff <= rate_ff;
         rsp_area_ff <= trap_area;
         rsp_ovf_ff  <= ovf_ff;
         rsp_last_ff <= fin_last;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.rate_index     = rsp_rate_ff;
   assign rsp_ch.area           = rsp_area_ff;
   assign rsp_ch.count_overflow = rsp_ovf_ff;
   assign rsp_ch.last_result    = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // A new request is never taken while memory writes are still pending.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !tmpl_busy)
      else $error("request accepted with update pipeline busy");

   // The sample count never passes the maximum.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("sample count beyond maximum");

   // The trapezoid unit only finishes while the sequencer waits for it.
   a_trap_owner: assert property (@(posedge clock) disable iff (reset)
      trap_done |-> (state_ff == ST_FIN_CALC))
      else $error("trapezoid result outside the result sequence");

   // Loading the final result of a block clears the block state.
   a_block_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && fin_last) |=> (count_ff == '0 && !ovf_ff && state_ff == ST_IDLE))
      else $error("block state not cleared after final result");
`endif

endmodule

### tb/sv/chirp_rate_correlator_bank_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for chirp_rate_correlator_bank_core: the rate results
// are predicted from the sample requests by a bit-true correlator model and checked.
// Depends on crcb_pkg, crcb_if and the block's RTL.
module chirp_rate_correlator_bank_core_tb;
   import crcb_pkg::*;

   localparam int  RUN_LIMIT     = 10_000_000;
   localparam int  SETTLE_CYCLES = 100;
   localparam int  END_CYCLES    = 200;
   localparam int  LONG_HOLD     = 3000;
   localparam int  TOTAL_ITEMS   = 230;
   localparam int  SAMPLE_LIMIT  = 1 << MAX_SAMPLES_LOG2;
   localparam int  TABLE_SIZE    = 1 << SINE_INDEX_BITS;
   localparam int  QUARTER_SIZE  = TABLE_SIZE / 4;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam longint unsigned AREA_LIM = 64'd1 << (AREA_W - 1);

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      logic                       last;
   } sample_req_type;

   typedef struct {
      logic [RATE_W-1:0]        rate;
      logic signed [AREA_W-1:0] area;
      logic                     ovf;
      logic                     last;
   } area_result_type;

   logic clock;
   logic reset;

   crcb_req_if req_ch ();
   crcb_rsp_if rsp_ch ();
   crcb_csr_if csr_ch ();

   chirp_rate_correlator_bank_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Configuration copy used by the correlator model.
   logic [PHASE_W-1:0] cfg_base_step = BASE_PHASE_STEP_RESET;
   logic [CU_W-1:0]    cfg_chirp     = CHIRP_UNIT_RESET;
   logic [TS_W-1:0]    cfg_time_step = TIME_STEP_RESET;
   logic [RATES_W-1:0] cfg_rates     = RATES_IN_USE_RESET;

   // Correlator model state, one entry per chirp rate.
   int                 sine_tab [TABLE_SIZE];
   logic [PHASE_W-1:0] tpl_phase [NUM_RATES];
   logic [PHASE_W-1:0] tpl_step [NUM_RATES];
   logic [SUM_W-1:0]   corr_sum [NUM_RATES];
   longint             head_prod [NUM_RATES];
   longint             tail_prod [NUM_RATES];
   int                 blk_samples = 0;
   logic               blk_overflow = 1'b0;

   sample_req_type  sample_queue [$];
   area_result_type pending_areas [$];

   int   cycle_count = 0;
   int   mismatch_count = 0;
   bit   jitter_on = 1'b0;
   bit   hold_armed = 1'b0;
   bit   req_hot = 1'b0;
   bit   sample_accepted = 1'b0;
   int   req_gap = 0;
   int   ready_gap = 0;
   int   hold_left = 0;
   bit   ready_now = 1'b0;
   sample_req_type next_req;

   // First-quadrant sine in Q15 from a truncated Taylor series in Q30.
   function automatic int quarter_wave(int unsigned m);
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned term;
      longint unsigned divisor;
      longint          acc;
      ang    = (64'(m) * QUARTER_TURN_Q30) >> (SINE_INDEX_BITS - 2);
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = longint'(ang);
      for (int k = 1; k <= 7; k++) begin
         divisor = 64'((2 * k) * (2 * k + 1));
         term    = ((term * ang_sq) >> 30) / divisor;
         if (k % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      acc = (acc + 16384) >> 15;
      if (acc > 32767) acc = 32767;
      return int'(acc);
   endfunction

   // Full-circle table by quadrant symmetry.
   function automatic void build_sine_tab();
      int quad;
      int m;
      int v;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         quad = i / QUARTER_SIZE;
         m    = i % QUARTER_SIZE;
         v    = (quad % 2 == 1) ? quarter_wave(QUARTER_SIZE - m) : quarter_wave(m);
         sine_tab[i] = (quad >= 2) ? -v : v;
      end
   endfunction

   // Trapezoid area of one rate: round(time_step * D / 2^33), saturated.
   function automatic logic signed [AREA_W-1:0] trapezoid_area(int r);
      logic signed [SUM_W-1:0] sum_s;
      longint                  twice;
      longint unsigned         mag;
      longint unsigned         x;
      longint unsigned         q;
      logic [95:0]             wide;
      sum_s = corr_sum[r];
      twice = 2 * longint'(sum_s) - head_prod[r] - tail_prod[r];
      mag   = (twice < 0) ? 64'(-twice) : 64'(twice);
      wide  = 96'(mag) * 96'(cfg_time_step);
      x     = wide[95:32];
      q     = (x + 64'd1) >> 1;
      if (twice < 0) begin
         if (q > AREA_LIM) q = AREA_LIM;
         return AREA_W'(64'd0 - q);
      end
      if (q > AREA_LIM - 1) q = AREA_LIM - 1;
      return AREA_W'(q);
   endfunction

   // Advance every template by one accepted sample; a last sample queues the areas.
   task automatic correlate_sample(logic signed [SAMPLE_W-1:0] value, logic last);
      longint          prod;
      int              n;
      area_result_type res;
      if (blk_samples == 0) begin
         for (int r = 0; r < NUM_RATES; r++) begin
            tpl_phase[r] = '0;
            tpl_step[r]  = cfg_base_step + PHASE_W'(cfg_chirp) * PHASE_W'(r);
            corr_sum[r]  = '0;
         end
      end
      if (blk_samples < SAMPLE_LIMIT) begin
         for (int r = 0; r < NUM_RATES; r++) begin
            prod = longint'(value) *
                   longint'(sine_tab[tpl_phase[r][PHASE_W-1 -: SINE_INDEX_BITS]]);
            if (blk_samples == 0) head_prod[r] = prod;
            tail_prod[r] = prod;
            corr_sum[r]  = corr_sum[r] + SUM_W'(prod);
            tpl_phase[r] = tpl_phase[r] + tpl_step[r];
            tpl_step[r]  = tpl_step[r] + PHASE_W'(cfg_chirp) * PHASE_W'(2 * r);
         end
         blk_samples++;
      end else begin
         // Samples past the count limit are dropped and only raise the flag.
         blk_overflow = 1'b1;
      end
      if (last) begin
         n = int'(cfg_rates);
         if (n < 1) n = 1;
         if (n > NUM_RATES) n = NUM_RATES;
         for (int r = 0; r < n; r++) begin
            res.rate = RATE_W'(r);
            res.area = trapezoid_area(r);
            res.ovf  = blk_overflow;
            res.last = (r == n - 1);
            pending_areas.insert(pending_areas.size(), res);
         end
         blk_samples  = 0;
         blk_overflow = 1'b0;
      end
   endtask

   task automatic flag_mismatch(string msg);
      // One line per mismatch, and a running count.
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // Compare one accepted result with the oldest pending area.
   task automatic check_area_result();
      area_result_type want;
      if (pending_areas.size() == 0) begin
         flag_mismatch($sformatf("result for rate %0d with nothing pending",
                                 rsp_ch.rate_index));
         return;
      end
      want = pending_areas.pop_front();
      if (rsp_ch.rate_index !== want.rate)
         flag_mismatch($sformatf("rate_index got %0d want %0d", rsp_ch.rate_index, want.rate));
      if (rsp_ch.area !== want.area)
         flag_mismatch($sformatf("area rate %0d got %0d want %0d",
                                 want.rate, rsp_ch.area, want.area));
      if (rsp_ch.count_overflow !== want.ovf)
         flag_mismatch($sformatf("count_overflow rate %0d got %0b want %0b",
                                 want.rate, rsp_ch.count_overflow, want.ovf));
      if (rsp_ch.last_result !== want.last)
         flag_mismatch($sformatf("last_result rate %0d got %0b want %0b",
                                 want.rate, rsp_ch.last_result, want.last));
   endtask

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (!jitter_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 150);
   endfunction

   // Sample value; only the low 16 bits are used.
   function automatic int pick_sample();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return -32768;
      if (roll < 20) return 32767;
      if (roll < 25) return 0;
      if (roll < 30) return -1;
      return int'($urandom_range(0, 65535));
   endfunction

   function automatic int pick_block_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return 1;
      if (roll < 80) return $urandom_range(2, 6);
      if (roll < 95) return $urandom_range(7, 16);
      return $urandom_range(17, 40);
   endfunction

   task automatic push_sample(int value, logic last);
      sample_req_type item;
      item.value = SAMPLE_W'(value);
      item.last  = last;
      sample_queue.insert(sample_queue.size(), item);
   endtask

   // One configuration write; the model copy follows at the handshake.
   task automatic csr_write(logic [CSR_INDEX_W-1:0] reg_index,
                            logic [CSR_DATA_W-1:0] reg_value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= reg_index;
      csr_ch.data  <= reg_value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (reg_index)
         REG_BASE_PHASE_STEP: cfg_base_step = reg_value[PHASE_W-1:0];
         REG_CHIRP_UNIT:      cfg_chirp     = reg_value[CU_W-1:0];
         REG_TIME_STEP:       cfg_time_step = reg_value[TS_W-1:0];
         REG_RATES_IN_USE:    cfg_rates     = reg_value[RATES_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Write all four registers; unused upper data bits sometimes carry junk.
   task automatic write_regs(logic [PHASE_W-1:0] base, logic [CU_W-1:0] chirp,
                             logic [TS_W-1:0] tstep, logic [RATES_W-1:0] rates);
      logic [63:0] junk;
      junk = $urandom_range(0, 1) ? {$urandom(), $urandom()} : 64'd0;
      csr_write(REG_BASE_PHASE_STEP, base);
      csr_write(REG_CHIRP_UNIT, {junk[CSR_DATA_W-CU_W-1:0], chirp});
      csr_write(REG_TIME_STEP, {junk[CSR_DATA_W-TS_W+7:8], tstep});
      csr_write(REG_RATES_IN_USE, {junk[CSR_DATA_W-RATES_W-1:0], rates});
   endtask

   task automatic random_config();
      logic [PHASE_W-1:0] base;
      logic [CU_W-1:0]    chirp;
      logic [TS_W-1:0]    tstep;
      logic [RATES_W-1:0] rates;
      case ($urandom_range(0, 4))
         0:       base = '0;
         1:       base = '1;
         2:       base = BASE_PHASE_STEP_RESET;
         default: base = PHASE_W'({$urandom(), $urandom()});
      endcase
      case ($urandom_range(0, 4))
         0:       chirp = '0;
         1:       chirp = '1;
         2:       chirp = $urandom_range(0, 200000);
         default: chirp = $urandom();
      endcase
      case ($urandom_range(0, 4))
         0:       tstep = '0;
         1:       tstep = '1;
         2:       tstep = TIME_STEP_RESET;
         default: tstep = $urandom();
      endcase
      case ($urandom_range(0, 6))
         0:       rates = '0;
         1:       rates = '1;
         2:       rates = RATES_W'(NUM_RATES);
         3:       rates = 7'd1;
         default: rates = RATES_W'($urandom_range(2, 127));
      endcase
      write_regs(base, chirp, tstep, rates);
   endtask

   // Wait until every request is taken and every area has arrived, then settle.
   task automatic wait_quiet(int settle);
      while (sample_queue.size() != 0 || req_hot || pending_areas.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: one request at a time, random gaps between requests.
   always @(negedge clock) begin
      if (reset) begin
         req_hot = 1'b0;
      end else if (sample_accepted || !req_hot) begin
         sample_accepted = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_hot = 1'b0;
         end else if (sample_queue.size() != 0) begin
            next_req = sample_queue.pop_front();
            req_ch.sample      <= next_req.value;
            req_ch.last_sample <= next_req.last;
            req_hot = 1'b1;
            req_gap = pick_gap();
         end else begin
            req_hot = 1'b0;
         end
      end
      req_ch.valid <= req_hot;
   end

   // Result receiver: random stalls plus one long hold-off to back up the block.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         ready_now = 1'b0;
      end else if (hold_armed && rsp_ch.valid) begin
         hold_armed = 1'b0;
         hold_left  = LONG_HOLD - 1;
         ready_now  = 1'b0;
      end else if (ready_gap > 0) begin
         ready_gap--;
         ready_now = 1'b0;
      end else begin
         ready_now = 1'b1;
         if ($urandom_range(0, 3) == 0) ready_gap = pick_gap();
      end
      rsp_ch.ready <= ready_now;
   end

   // Monitor: predict on each accepted request, check each accepted result.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_ch.valid && req_ch.ready) begin
         correlate_sample(req_ch.sample, req_ch.last_sample);
         sample_accepted = 1'b1;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_area_result();
   end

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int items_left;
      int blocks;
      int len;
      bit first_phase;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.sample      = '0;
      req_ch.last_sample = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = REG_BASE_PHASE_STEP;
      csr_ch.data        = '0;
      build_sine_tab();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: a one-sample block, then a short block of extremes.
      jitter_on = 1'b0;
      push_sample(32767, 1'b1);
      push_sample(-32768, 1'b0);
      push_sample(32767, 1'b0);
      push_sample(0, 1'b0);
      push_sample(-1, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // Widest steps and time step; rate count zero reports a single rate.
      jitter_on = 1'b1;
      write_regs('1, '1, '1, 7'd0);
      push_sample(-32768, 1'b0);
      push_sample(-32768, 1'b0);
      push_sample(-32768, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // Zero steps and time step; the largest rate count clamps to the bank size.
      write_regs('0, '0, '0, '1);
      push_sample(12345, 1'b0);
      push_sample(-12345, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // Rate count just over the bank size, alternating full-scale samples.
      write_regs(PHASE_W'({$urandom(), $urandom()}), $urandom(), '1, 7'd65);
      push_sample(32767, 1'b0);
      push_sample(-32768, 1'b0);
      push_sample(32767, 1'b0);
      push_sample(-32768, 1'b0);
      push_sample(16'sh5555, 1'b0);
      push_sample(16'shAAAA, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // One rate, half-scale time step, a random block and a lone sample.
      write_regs(BASE_PHASE_STEP_RESET, CHIRP_UNIT_RESET, 32'h8000_0000, 7'd1);
      for (int i = 0; i < 8; i++) push_sample(pick_sample(), i == 7);
      push_sample(-32768, 1'b1);
      items_left = TOTAL_ITEMS - 25;

      // Random phases: a fresh setting, then a few whole blocks of samples.
      first_phase = 1'b1;
      while (items_left > 0) begin
         wait_quiet(SETTLE_CYCLES);
         random_config();
         jitter_on = ($urandom_range(0, 3) != 0);
         blocks = $urandom_range(2, 5);
         for (int b = 0; b < blocks && items_left > 0; b++) begin
            len = pick_block_len();
            for (int i = 0; i < len; i++) push_sample(pick_sample(), i == len - 1);
            items_left -= len;
         end
         if (first_phase) begin
            hold_armed  = 1'b1;
            first_phase = 1'b0;
         end
      end

      wait_quiet(END_CYCLES);
      if (mismatch_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

### chirp_rate_correlator_bank_core.f
rtl/crcb_pkg.sv
rtl/crcb_if.sv
rtl/crcb_ram.sv
rtl/crcb_tmpl.sv
rtl/crcb_trap.sv
rtl/chirp_rate_correlator_bank_core.sv
tb/sv/chirp_rate_correlator_bank_core_tb.sv
